FILE: rtl/pqsm_pkg.sv
// ----------------------------------------------------------------------------
// pqsm_pkg: shared types and constants of the stable max priority queue
// Entry, scan token and per-cell control types plus status codes.
// ----------------------------------------------------------------------------
package pqsm_pkg;

    localparam int VAL_W            = 16;
    localparam int PRI_W            = 4;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SERVE  = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Running best candidate that walks down the row of cells.
    typedef struct packed {
        logic   valid;
        logic   found;
        entry_t best;
    } token_t;

    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t ins_entry;
    } cell_ctrl_t;

endpackage

FILE: rtl/pqsm_cell.sv
// ----------------------------------------------------------------------------
// pqsm_cell: one slot of the queue
// Holds one entry, updates the passing scan token, and shifts toward the head.
// ----------------------------------------------------------------------------
module pqsm_cell
    import pqsm_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  token_t           token_i,
    input  logic [IDX_W-1:0] idx_i,
    output token_t           token_o,
    output logic [IDX_W-1:0] idx_o,
    input  cell_ctrl_t       ctrl_i,
    input  logic [CNT_W-1:0] count_i,
    input  logic [IDX_W-1:0] best_idx_i,
    input  entry_t           next_entry_i,
    output entry_t           entry_o
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    entry_t           entry_reg;
    token_t           token_reg;
    token_t           token_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             occupied;
    logic             take;

    assign occupied = (MY_POS < count_i);
    // Strict compare keeps the older entry on a tie.
    assign take = token_i.valid && occupied &&
                  (!token_i.found || (entry_reg.pri > token_i.best.pri));

    always_comb begin
        token_next       = token_i;
        token_next.found = token_i.found | take;
        token_next.best  = take ? entry_reg : token_i.best;
        idx_next         = take ? MY_IDX : idx_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg.valid <= 1'b0;
        end else begin
            token_reg <= token_next;
        end
        idx_reg <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.remove && (MY_IDX >= best_idx_i)) begin
            entry_reg <= next_entry_i;
        end else if (ctrl_i.insert && (count_i == MY_POS)) begin
            entry_reg <= ctrl_i.ins_entry;
        end
    end

    assign token_o = token_reg;
    assign idx_o   = idx_reg;
    assign entry_o = entry_reg;

endmodule

FILE: rtl/priority_queue_stable_max.sv
// ----------------------------------------------------------------------------
// priority_queue_stable_max: bounded priority queue with oldest-first ties
// A row of cells keeps entries in arrival order; a serve scans the row for
// the highest priority and closes the gap behind the chosen entry.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                  | tuser
//  --------+-----------+-------------------------------------+------------------
//  s_      | in        | item_value[15:0], item_priority[19:16] | req_type[0]
//  m_      | out       | served_value[15:0], served_priority[19:16] | status[1:0]
//
// An insert, a serve on an empty queue and an insert on a full queue are
// answered from the result register in the cycle after acceptance. A serve on
// a non-empty queue sends the scan token down the row of cells one cell per
// cycle; when it leaves the last cell the winner is removed and the result
// register is loaded. Reset (aresetn low, synchronous) empties the queue and
// clears the result valid flag. While a result waits in the output register the
// block accepts a new transaction only if m_tready takes it in the same cycle.
module priority_queue_stable_max
    import pqsm_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // item_value[15:0], item_priority[19:16], zero pad
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // served_value[15:0], served_priority[19:16], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Controller states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    entry_t              m_entry_reg, m_entry_next;

    token_t              tok   [CAPACITY+1];
    logic [IDX_W-1:0]    idx   [CAPACITY+1];
    entry_t              entry [CAPACITY];
    cell_ctrl_t          ctrl;

    logic accept, is_serve, full, empty, start, done;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_serve = (s_tuser[0] == REQ_SERVE);
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign start    = accept && is_serve && !empty;
    // The token leaves the last cell carrying the oldest highest-priority entry.
    assign done     = (state_reg == ST_SCAN) && tok[CAPACITY].valid;

    // Head of the chain: a fresh token with no candidate yet.
    assign tok[0] = '{valid: start, found: 1'b0, best: '0};
    assign idx[0] = '0;

    assign ctrl.insert        = accept && !is_serve && !full;
    assign ctrl.remove        = done;
    assign ctrl.ins_entry.val = s_tdata[VAL_W-1:0];
    assign ctrl.ins_entry.pri = s_tdata[VAL_W+PRI_W-1:VAL_W];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t next_entry;
        if (i < CAPACITY - 1) begin : g_mid
            assign next_entry = entry[i+1];
        end else begin : g_last
            assign next_entry = entry[i];
        end

        pqsm_cell #(
            .INDEX (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .token_i      (tok[i]),
            .idx_i        (idx[i]),
            .token_o      (tok[i+1]),
            .idx_o        (idx[i+1]),
            .ctrl_i       (ctrl),
            .count_i      (count_reg),
            .best_idx_i   (idx[CAPACITY]),
            .next_entry_i (next_entry),
            .entry_o      (entry[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_entry_next  = m_entry_reg;

        if (start) begin
            state_next = ST_SCAN;
        end else if (accept) begin
            // Every request other than a serve on a non-empty queue answers at once.
            m_valid_next  = 1'b1;
            m_entry_next  = '0;
            if (is_serve) begin
                m_status_next = ST_EMPTY;
            end else if (full) begin
                m_status_next = ST_FULL;
            end else begin
                m_status_next = ST_INSERTED;
                count_next    = count_reg + 1'b1;
            end
        end

        if (done) begin
            state_next    = ST_IDLE;
            count_next    = count_reg - 1'b1;
            m_valid_next  = 1'b1;
            m_status_next = ST_SERVED;
            m_entry_next  = tok[CAPACITY].best;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(24 - VAL_W - PRI_W){1'b0}}, m_entry_reg.pri, m_entry_reg.val};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_done_found: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> tok[CAPACITY].found)
        else $error("scan finished without a candidate");

    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[CAPACITY].valid |-> (state_reg == ST_SCAN))
        else $error("scan token outside a serve");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the queue");

    a_serve_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (m_tvalid && (m_tuser == ST_SERVED) && (state_reg == ST_IDLE)))
        else $error("serve result not presented");
`endif

endmodule
